FILE: hdl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg: shared constants for the Givens rotation coefficient block
// Default widths for the input components and the fixed point results.
// ----------------------------------------------------------------------------
package grc_pkg;

    // default input component width
    localparam int IN_WIDTH_DEF  = 32;
    // default number of fraction bits in cosine and sine
    localparam int FRAC_BITS_DEF = 30;

endpackage

FILE: hdl/grc_cell.sv
// ----------------------------------------------------------------------------
// grc_cell: one result bit of the scaled ratio search
// Tries one bit of the rounded ratio and keeps it if the residual stays
// non-negative, updating the residual and the running product in place.
// ----------------------------------------------------------------------------
module grc_cell #(
    parameter int IN_WIDTH  = grc_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = grc_pkg::FRAC_BITS_DEF,
    parameter int BIT_POS   = 0
) (
    input  logic                                       aclk,
    input  logic                                       ce,
    input  logic [2*IN_WIDTH-1:0]                      rsq_in,
    input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]   e_in,
    input  logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]   p_in,
    input  logic [FRAC_BITS:0]                         acc_in,
    output logic [2*IN_WIDTH-1:0]                      rsq_out,
    output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]   e_out,
    output logic signed [2*IN_WIDTH+2*FRAC_BITS+3:0]   p_out,
    output logic [FRAC_BITS:0]                         acc_out
);
    import grc_pkg::*;

    localparam int RW = 2 * IN_WIDTH;
    localparam int AW = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
    localparam int AF = FRAC_BITS + 1;
    localparam logic [AF-1:0] BIT_MASK = AF'(1) << BIT_POS;

    logic signed [AW-1:0] rsq_ext;
    logic signed [AW-1:0] step_val;
    logic signed [AW-1:0] e_diff;
    logic                 take;

    // residual cost of raising the odd multiplier by 2^(BIT_POS+1)
    assign rsq_ext  = $signed({{(AW-RW){1'b0}}, rsq_in});
    assign step_val = (p_in <<< (BIT_POS + 2)) + (rsq_ext <<< (2 * BIT_POS + 2));
    assign e_diff   = e_in - step_val;
    assign take     = !e_diff[AW-1];

    // advance the search state to the next cell
    always_ff @(posedge aclk) begin
        if (ce) begin
            rsq_out <= rsq_in;
            if (take) begin
                e_out   <= e_diff;
                p_out   <= p_in + (rsq_ext <<< (BIT_POS + 1));
                acc_out <= acc_in | BIT_MASK;
            end else begin
                e_out   <= e_in;
                p_out   <= p_in;
                acc_out <= acc_in;
            end
        end
    end

endmodule

FILE: hdl/givens_rotation_coefficients_top.sv
// ----------------------------------------------------------------------------
// givens_rotation_coefficients_top: Givens cosine and sine generator
// Turns a pair (a, b) into the rotation cosine and sine in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pair per transfer: a in the low IN_WIDTH bits of
//   s_tdata, b in the next IN_WIDTH bits. m_axis returns one result per
//   pair: cosine in the low FRAC_BITS+2 bits of m_tdata, sine above it,
//   both with 2^FRAC_BITS meaning 1.0, rounded to nearest and clamped.
//   Throughput is one pair per cycle unless a stalled receiver holds the
//   pipeline; each result bit is settled by one cell of a row of
//   FRAC_BITS+1 cells, two rows side by side. Stages: magnitude, square,
//   sum, the cells in order, and the output register.
//   Reset (aresetn low, synchronous) empties the pipeline; no result is
//   pending afterward. When m_tready is low and a result waits, the whole
//   pipeline holds and s_tready drops; results are neither lost nor
//   repeated.
// ----------------------------------------------------------------------------
module givens_rotation_coefficients_top #(
    parameter int IN_WIDTH  = grc_pkg::IN_WIDTH_DEF,
    parameter int FRAC_BITS = grc_pkg::FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // fields from bit 0: first_value, second_value, zero fill
    input  logic [((2*IN_WIDTH+7)/8)*8-1:0]           s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // fields from bit 0: cosine, sine, zero fill
    output logic [((2*(FRAC_BITS+2)+7)/8)*8-1:0]      m_tdata
);
    import grc_pkg::*;

    localparam int IW  = IN_WIDTH;
    localparam int RW  = 2 * IN_WIDTH;
    localparam int AW  = 2 * IN_WIDTH + 2 * FRAC_BITS + 4;
    localparam int AF  = FRAC_BITS + 1;
    localparam int OW  = FRAC_BITS + 2;
    localparam int NC  = FRAC_BITS + 1;
    localparam int MDW = ((2 * OW + 7) / 8) * 8;
    localparam int SB  = 3;
    localparam logic [OW-1:0] ONE_FIX = OW'(1) << FRAC_BITS;

    logic ce;

    // pipeline advances unless a result waits on a stalled receiver
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // stage 1: magnitudes and signs
    logic [IW-1:0] a_in, b_in;
    logic [IW-1:0] ma_reg, mb_reg;
    logic          na_reg, nb_reg;
    assign a_in = s_tdata[IW-1:0];
    assign b_in = s_tdata[2*IW-1:IW];

    always_ff @(posedge aclk) begin
        if (ce) begin
            na_reg <= a_in[IW-1];
            nb_reg <= b_in[IW-1];
            ma_reg <= a_in[IW-1] ? (~a_in + IW'(1)) : a_in;
            mb_reg <= b_in[IW-1] ? (~b_in + IW'(1)) : b_in;
        end
    end

    // stage 2: squares and branch flags
    logic [RW-1:0] sa_reg, sb_reg;
    logic [SB-1:0] side2_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            sa_reg    <= RW'(ma_reg) * RW'(ma_reg);
            sb_reg    <= RW'(mb_reg) * RW'(mb_reg);
            side2_reg <= {mb_reg == '0, mb_reg > ma_reg, na_reg ^ nb_reg};
        end
    end

    // stage 3: radius squared and initial residuals
    logic [RW-1:0]        rsq_sum;
    logic signed [AW-1:0] rsq_ext, sa_ext, sb_ext;
    logic [SB-1:0]        side [0:NC];
    logic [RW-1:0]        rsq_a [0:NC];
    logic [RW-1:0]        rsq_b [0:NC];
    logic signed [AW-1:0] e_a [0:NC];
    logic signed [AW-1:0] e_b [0:NC];
    logic signed [AW-1:0] p_a [0:NC];
    logic signed [AW-1:0] p_b [0:NC];
    logic [AF-1:0]        acc_a [0:NC];
    logic [AF-1:0]        acc_b [0:NC];

    assign rsq_sum = sa_reg + sb_reg;
    assign rsq_ext = $signed({{(AW-RW){1'b0}}, rsq_sum});
    assign sa_ext  = $signed({{(AW-RW){1'b0}}, sa_reg});
    assign sb_ext  = $signed({{(AW-RW){1'b0}}, sb_reg});

    always_ff @(posedge aclk) begin
        if (ce) begin
            rsq_a[0] <= rsq_sum;
            rsq_b[0] <= rsq_sum;
            e_a[0]   <= (sa_ext <<< (2 * FRAC_BITS + 2)) - rsq_ext;
            e_b[0]   <= (sb_ext <<< (2 * FRAC_BITS + 2)) - rsq_ext;
            p_a[0]   <= -rsq_ext;
            p_b[0]   <= -rsq_ext;
            acc_a[0] <= '0;
            acc_b[0] <= '0;
            side[0]  <= side2_reg;
        end
    end

    // rows of cells, most significant result bit first
    for (genvar i = 0; i < NC; i++) begin : g_cell
        grc_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (FRAC_BITS - i)
        ) u_cell_a (
            .aclk    (aclk),
            .ce      (ce),
            .rsq_in  (rsq_a[i]),
            .e_in    (e_a[i]),
            .p_in    (p_a[i]),
            .acc_in  (acc_a[i]),
            .rsq_out (rsq_a[i+1]),
            .e_out   (e_a[i+1]),
            .p_out   (p_a[i+1]),
            .acc_out (acc_a[i+1])
        );
        grc_cell #(
            .IN_WIDTH  (IN_WIDTH),
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (FRAC_BITS - i)
        ) u_cell_b (
            .aclk    (aclk),
            .ce      (ce),
            .rsq_in  (rsq_b[i]),
            .e_in    (e_b[i]),
            .p_in    (p_b[i]),
            .acc_in  (acc_b[i]),
            .rsq_out (rsq_b[i+1]),
            .e_out   (e_b[i+1]),
            .p_out   (p_b[i+1]),
            .acc_out (acc_b[i+1])
        );
        always_ff @(posedge aclk) begin
            if (ce) begin
                side[i+1] <= side[i];
            end
        end
    end

    // clamp, sign and special case
    logic [OW-1:0] mag_a, mag_b, cos_val, sin_val;
    logic          b_zero, b_gt, neg_x;
    assign {b_zero, b_gt, neg_x} = side[NC];
    assign mag_a = ({1'b0, acc_a[NC]} > ONE_FIX) ? ONE_FIX : {1'b0, acc_a[NC]};
    assign mag_b = ({1'b0, acc_b[NC]} > ONE_FIX) ? ONE_FIX : {1'b0, acc_b[NC]};

    always_comb begin
        if (b_zero) begin
            cos_val = ONE_FIX;
            sin_val = '0;
        end else if (b_gt) begin
            cos_val = neg_x ? (~mag_a + OW'(1)) : mag_a;
            sin_val = mag_b;
        end else begin
            cos_val = mag_a;
            sin_val = neg_x ? (~mag_b + OW'(1)) : mag_b;
        end
    end

    // output register
    logic [MDW-1:0] m_tdata_reg;
    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {{(MDW-2*OW){1'b0}}, sin_val, cos_val};
        end
    end
    assign m_tdata = m_tdata_reg;

    // valid bits track each stage
    localparam int NV = NC + 4;
    logic [NV-1:0] valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[NV-2:0], s_tvalid};
        end
    end
    assign m_tvalid = valid_reg[NV-1];

endmodule
